FILE: design/multi_queue_byte_fifo_bank_top_defines.svh
// Assertion helpers shared by the RTL.
`ifndef MULTI_QUEUE_BYTE_FIFO_BANK_TOP_DEFINES_SVH
`define MULTI_QUEUE_BYTE_FIFO_BANK_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define MQFB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mqfb: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define MQFB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mqfb: next-cycle check failed");

`endif

FILE: design/mqfb_pkg.sv
package mqfb_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned MAX_QUEUES  = 16;
  localparam int unsigned CMDQ_DEPTH  = 2;

  localparam int unsigned QIDX_W = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = PTR_W + 1;
  localparam int unsigned TOT_W  = $clog2(MAX_QUEUES + 1);
  localparam int unsigned CMP_W  = (TOT_W > 5) ? TOT_W : 5;
  localparam int unsigned ADDR_W = $clog2(MAX_QUEUES * QUEUE_DEPTH);
  localparam int unsigned STORE_DEPTH = MAX_QUEUES * QUEUE_DEPTH;
  localparam int unsigned CQP_W  = $clog2(CMDQ_DEPTH);
  localparam int unsigned CQC_W  = $clog2(CMDQ_DEPTH + 1);

  typedef logic [QIDX_W-1:0] qidx_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [TOT_W-1:0]  total_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CQP_W-1:0]  cqptr_t;
  typedef logic [CQC_W-1:0]  cqcnt_t;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_ENQUEUE = 2'd1,
    REQ_DEQUEUE = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_NOQUEUE = 3'd3,
    ST_NOLEFT  = 3'd4
  } status_e;

  // Work left for the back end after classification.
  typedef enum logic [1:0] {
    OP_DONE    = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2
  } op_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] queue_id;
    logic [7:0] data_in;
  } req_t;

  typedef struct packed {
    logic [7:0] data_out;
    status_e    status;
    logic [4:0] active_queues;
  } rsp_t;

  typedef struct packed {
    op_e        op;
    status_e    status;
    qidx_t      qidx;
    logic [7:0] data;
    logic [4:0] active;
  } cmd_t;

endpackage

FILE: design/mqfb_ram.sv
module mqfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mqfb_front.sv
module mqfb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  mqfb_pkg::req_t  req_i,
  output mqfb_pkg::cmd_t  cmd_o
);

  mqfb_pkg::total_t total_q, total_d;
  logic             id_ok;

  // A queue number is valid from one up to the current total.
  assign id_ok = (req_i.queue_id != 5'd0) &&
                 (mqfb_pkg::cmp_t'(req_i.queue_id) <= mqfb_pkg::cmp_t'(total_q));

  always_comb begin
    total_d       = total_q;
    cmd_o.op      = mqfb_pkg::OP_DONE;
    cmd_o.status  = mqfb_pkg::ST_OK;
    cmd_o.qidx    = mqfb_pkg::qidx_t'(req_i.queue_id - 5'd1);
    cmd_o.data    = req_i.data_in;
    unique case (mqfb_pkg::req_type_e'(req_i.req_type))
      mqfb_pkg::REQ_CREATE: begin
        if (total_q < mqfb_pkg::total_t'(mqfb_pkg::MAX_QUEUES)) begin
          total_d = total_q + mqfb_pkg::total_t'(1);
        end else begin
          cmd_o.status = mqfb_pkg::ST_NOLEFT;
        end
      end
      mqfb_pkg::REQ_ENQUEUE: begin
        if (id_ok) begin
          cmd_o.op = mqfb_pkg::OP_ENQUEUE;
        end else begin
          cmd_o.status = mqfb_pkg::ST_NOQUEUE;
        end
      end
      mqfb_pkg::REQ_DEQUEUE: begin
        if (id_ok) begin
          cmd_o.op = mqfb_pkg::OP_DEQUEUE;
        end else begin
          cmd_o.status = mqfb_pkg::ST_NOQUEUE;
        end
      end
      default: begin
        cmd_o.status = mqfb_pkg::ST_OK;
      end
    endcase
    cmd_o.active = 5'(total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= mqfb_pkg::total_t'(1);
    end else if (accept_i) begin
      total_q <= total_d;
    end
  end

endmodule

FILE: design/mqfb_cmd_fifo.sv
module mqfb_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mqfb_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output mqfb_pkg::cmd_t pop_data_o,
  output logic           full_o,
  output logic           empty_o
);

  mqfb_pkg::cmd_t   entry_q [mqfb_pkg::CMDQ_DEPTH];
  mqfb_pkg::cqptr_t wr_ptr_q, rd_ptr_q;
  mqfb_pkg::cqcnt_t count_q;

  function automatic mqfb_pkg::cqptr_t ptr_inc(input mqfb_pkg::cqptr_t p);
    if (p == mqfb_pkg::cqptr_t'(mqfb_pkg::CMDQ_DEPTH - 1)) begin
      return '0;
    end
    return p + mqfb_pkg::cqptr_t'(1);
  endfunction

  assign full_o     = (count_q == mqfb_pkg::cqcnt_t'(mqfb_pkg::CMDQ_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + mqfb_pkg::cqcnt_t'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - mqfb_pkg::cqcnt_t'(1);
      end
    end
  end

endmodule

FILE: design/mqfb_back.sv
module mqfb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  mqfb_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           rsp_valid_o,
  output mqfb_pkg::rsp_t rsp_o
);

  mqfb_pkg::back_state_e state_q, state_d;
  mqfb_pkg::ptr_t        head_q [mqfb_pkg::MAX_QUEUES];
  mqfb_pkg::cnt_t        fill_q [mqfb_pkg::MAX_QUEUES];
  mqfb_pkg::rsp_t        rsp_q, rsp_d;
  logic                  rsp_valid_q, rsp_valid_d;

  mqfb_pkg::ptr_t  head_cur, tail_pos, head_wdata;
  mqfb_pkg::cnt_t  fill_cur, fill_wdata;
  mqfb_pkg::sum_t  tail_sum;
  mqfb_pkg::addr_t base_addr;
  logic            head_we, fill_we, ram_we, ram_re;
  logic [7:0]      ram_rdata;

  assign head_cur  = head_q[cmd_i.qidx];
  assign fill_cur  = fill_q[cmd_i.qidx];
  assign base_addr = mqfb_pkg::addr_t'(cmd_i.qidx) *
                     mqfb_pkg::addr_t'(mqfb_pkg::QUEUE_DEPTH);
  assign tail_sum  = mqfb_pkg::sum_t'(head_cur) + mqfb_pkg::sum_t'(fill_cur);
  // Wrap the tail; the sum stays below twice the depth.
  assign tail_pos  = (tail_sum >= mqfb_pkg::sum_t'(mqfb_pkg::QUEUE_DEPTH)) ?
                     mqfb_pkg::ptr_t'(tail_sum - mqfb_pkg::sum_t'(mqfb_pkg::QUEUE_DEPTH)) :
                     mqfb_pkg::ptr_t'(tail_sum);

  mqfb_ram #(
    .WIDTH (8),
    .DEPTH (mqfb_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (base_addr + mqfb_pkg::addr_t'(tail_pos)),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (base_addr + mqfb_pkg::addr_t'(head_cur)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    head_we     = 1'b0;
    fill_we     = 1'b0;
    head_wdata  = (head_cur == mqfb_pkg::ptr_t'(mqfb_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : head_cur + mqfb_pkg::ptr_t'(1);
    fill_wdata  = fill_cur;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    unique case (state_q)
      mqfb_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o               = 1'b1;
          rsp_d.data_out      = '0;
          rsp_d.status        = cmd_i.status;
          rsp_d.active_queues = cmd_i.active;
          unique case (cmd_i.op)
            mqfb_pkg::OP_ENQUEUE: begin
              rsp_valid_d = 1'b1;
              if (fill_cur == mqfb_pkg::cnt_t'(mqfb_pkg::QUEUE_DEPTH)) begin
                rsp_d.status = mqfb_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                fill_we    = 1'b1;
                fill_wdata = fill_cur + mqfb_pkg::cnt_t'(1);
              end
            end
            mqfb_pkg::OP_DEQUEUE: begin
              if (fill_cur == '0) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = mqfb_pkg::ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                head_we    = 1'b1;
                fill_we    = 1'b1;
                fill_wdata = fill_cur - mqfb_pkg::cnt_t'(1);
                state_d    = mqfb_pkg::BK_READ;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end
      mqfb_pkg::BK_READ: begin
        rsp_valid_d    = 1'b1;
        rsp_d.data_out = ram_rdata;
        state_d        = mqfb_pkg::BK_IDLE;
      end
      default: begin
        state_d = mqfb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mqfb_pkg::BK_IDLE;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < mqfb_pkg::MAX_QUEUES; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (head_we) begin
        head_q[cmd_i.qidx] <= head_wdata;
      end
      if (fill_we) begin
        fill_q[cmd_i.qidx] <= fill_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: design/multi_queue_byte_fifo_bank_top.sv
// Bank of byte FIFOs with one result per request. A request is taken on a
// rising edge where start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_valid_o high, in request order.
// The receiver cannot stall: sample rsp_o whenever rsp_valid_o is high.
// A successful dequeue takes a further read state for the registered
// read of the byte store. The back end retires one create or enqueue per
// cycle while not in that read state, and takes no new command until a
// successful dequeue has returned its byte; a two-entry command queue
// between the front end and the back end absorbs the difference, and
// busy is high while that queue is full.
// After reset one queue is active and all queues are empty; no clearing
// pass is needed, so requests are taken as soon as reset is released.
`include "multi_queue_byte_fifo_bank_top_defines.svh"

module multi_queue_byte_fifo_bank_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  mqfb_pkg::req_t req_i,
  output logic           busy,
  output logic           rsp_valid_o,
  output mqfb_pkg::rsp_t rsp_o
);

  mqfb_pkg::cmd_t front_cmd;
  mqfb_pkg::cmd_t back_cmd;
  logic           accept;
  logic           cmdq_full;
  logic           cmdq_empty;
  logic           cmdq_pop;
  logic           rsp_failed;

  // Take a transfer only while the command queue has room.
  assign busy   = cmdq_full;
  assign accept = start && !cmdq_full;

  // Front end: classify the request and track the active queue count.
  mqfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .cmd_o    (front_cmd)
  );

  // Hold classified commands until the back end can take them.
  mqfb_cmd_fifo u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_cmd),
    .pop_i       (cmdq_pop),
    .pop_data_o  (back_cmd),
    .full_o      (cmdq_full),
    .empty_o     (cmdq_empty)
  );

  // Back end: update queue pointers, access the byte store, drive results.
  mqfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (cmdq_empty),
    .cmd_i       (back_cmd),
    .pop_o       (cmdq_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // A result that reports any failure carries no byte.
  assign rsp_failed = rsp_valid_o && (rsp_o.status != mqfb_pkg::ST_OK);

  `MQFB_ASSERT_IMP(a_pop_not_empty, cmdq_pop, !cmdq_empty)
  `MQFB_ASSERT_IMP(a_busy_has_work, busy, !cmdq_empty)
  `MQFB_ASSERT_IMP(a_fail_no_data, rsp_failed, rsp_o.data_out == 8'd0)
  `MQFB_ASSERT_NXT(a_accept_queued, accept, !cmdq_empty)

endmodule
